### sv/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg
// Shared constants, types and helpers for the integer-to-ASCII radix converter.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam int VALUE_W     = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int STORE_DEPTH = VALUE_W + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_DIVIDE,
    S_DIGIT,
    S_SIGN,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture magnitude and sign of a new number
    logic div_step;   // one restoring-division bit
    logic digit_wr;   // store the digit of the remainder, restart divider
    logic sign_wr;    // store the minus sign
    logic emit_init;  // point the read pointer at the top character
    logic rd_en;      // read one character from the store
    logic out_load;   // move the read character to the output register
    logic out_empty;  // load the empty-string result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic radix_ok;
    logic div_last;
    logic quot_zero;
    logic count_full;
    logic negative;
    logic rd_last;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < RADIX_W'(10)) begin
      digit_char = CHAR_ZERO + d_ext;
    end else begin
      digit_char = CHAR_A + d_ext - CHAR_W'(10);
    end
  endfunction

endpackage

### sv/itar_ctrl.sv
// ----------------------------------------------------------------------------
// itar_ctrl
// Sequencer: division per digit, sign insertion, then character emission, or the empty result for an invalid radix.
// ----------------------------------------------------------------------------
module itar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itar_pkg::ctrl_sts_t sts,
  output itar_pkg::ctrl_cmd_t cmd
);

  itar_pkg::state_t state;
  itar_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itar_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      itar_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.radix_ok ? itar_pkg::S_DIVIDE : itar_pkg::S_EMPTY;
        end
      end
      itar_pkg::S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = itar_pkg::S_IDLE;
        end
      end
      itar_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = itar_pkg::S_DIGIT;
        end
      end
      itar_pkg::S_DIGIT: begin
        cmd.digit_wr = 1'b1;
        if (!sts.quot_zero && !sts.count_full) begin
          state_next = itar_pkg::S_DIVIDE;
        end else if (sts.negative) begin
          state_next = itar_pkg::S_SIGN;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = itar_pkg::S_EMIT_RD;
        end
      end
      itar_pkg::S_SIGN: begin
        cmd.sign_wr   = 1'b1;
        cmd.emit_init = 1'b1;
        state_next    = itar_pkg::S_EMIT_RD;
      end
      itar_pkg::S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = itar_pkg::S_EMIT_LD;
      end
      itar_pkg::S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = sts.rd_last ? itar_pkg::S_IDLE : itar_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = itar_pkg::S_IDLE;
      end
    endcase
  end

  a_digit_after_divide: assert property (@(posedge clk) disable iff (rst)
    state == itar_pkg::S_DIGIT |-> $past(state) == itar_pkg::S_DIVIDE)
    else $error("digit stored without a finished division");

  a_load_needs_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load || cmd.out_empty) |-> sts.out_free)
    else $error("output register overwritten while held");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != itar_pkg::S_IDLE)
    else $error("accepted number did not start a conversion");

endmodule

### sv/itar_dpath.sv
// ----------------------------------------------------------------------------
// itar_dpath
// Radix register, bit-serial divider, character store and output register.
// ----------------------------------------------------------------------------
module itar_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [itar_pkg::RADIX_W-1:0]         cfg_wr_data,
  input  logic signed [itar_pkg::VALUE_W-1:0]  number,
  input  itar_pkg::ctrl_cmd_t                  cmd,
  output itar_pkg::ctrl_sts_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [itar_pkg::CHAR_W-1:0]          ascii_char,
  output logic                                 last_char,
  output logic                                 empty_string
);

  logic [itar_pkg::RADIX_W-1:0]   radix;
  logic [itar_pkg::VALUE_W-1:0]   quot;
  logic [itar_pkg::RADIX_W-1:0]   rem;
  logic                           negative;
  logic [itar_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [itar_pkg::ADDR_W-1:0]    char_count;
  logic [itar_pkg::ADDR_W-1:0]    rd_ptr;
  logic [itar_pkg::CHAR_W-1:0]    rd_data;
  logic [itar_pkg::CHAR_W-1:0]    store [itar_pkg::STORE_DEPTH];

  logic [itar_pkg::VALUE_W-1:0]   num_u;
  logic [itar_pkg::VALUE_W-1:0]   mag;
  logic [itar_pkg::RADIX_W:0]     rem_shift;
  logic [itar_pkg::RADIX_W:0]     rem_diff;
  logic                           rem_ge;
  logic                           wr_en;
  logic [itar_pkg::CHAR_W-1:0]    wr_data;
  logic                           out_free;

  assign num_u = $unsigned(number);
  assign mag   = num_u[itar_pkg::VALUE_W-1] ? (~num_u + itar_pkg::VALUE_W'(1)) : num_u;

  // Restoring division step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem, quot[itar_pkg::VALUE_W-1]};
  assign rem_diff  = rem_shift - {1'b0, radix};
  assign rem_ge    = rem_shift >= {1'b0, radix};

  assign wr_en   = cmd.digit_wr || cmd.sign_wr;
  assign wr_data = cmd.sign_wr ? itar_pkg::CHAR_MINUS : itar_pkg::digit_char(rem);

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts            = '0;
    sts.radix_ok   = (radix >= itar_pkg::RADIX_MIN) && (radix <= itar_pkg::RADIX_MAX);
    sts.div_last   = bit_cnt == itar_pkg::BIT_CNT_W'(itar_pkg::VALUE_W - 1);
    sts.quot_zero  = quot == '0;
    sts.count_full = char_count == itar_pkg::ADDR_W'(itar_pkg::STORE_DEPTH - 2);
    sts.negative   = negative;
    sts.rd_last    = rd_ptr == '0;
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itar_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quot       <= '0;
      rem        <= '0;
      bit_cnt    <= '0;
      char_count <= '0;
      negative   <= 1'b0;
    end else begin
      if (cmd.load) begin
        quot       <= mag;
        rem        <= '0;
        bit_cnt    <= '0;
        char_count <= '0;
        negative   <= num_u[itar_pkg::VALUE_W-1];
      end
      if (cmd.div_step) begin
        quot    <= {quot[itar_pkg::VALUE_W-2:0], rem_ge};
        rem     <= rem_ge ? rem_diff[itar_pkg::RADIX_W-1:0] : rem_shift[itar_pkg::RADIX_W-1:0];
        bit_cnt <= bit_cnt + itar_pkg::BIT_CNT_W'(1);
      end
      if (cmd.digit_wr) begin
        rem     <= '0;
        bit_cnt <= '0;
      end
      if (wr_en) begin
        char_count <= char_count + itar_pkg::ADDR_W'(1);
      end
    end
  end

  // Character store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[char_count] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= store[rd_ptr];
    end
  end

  // Read pointer walks down from the top character
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      rd_ptr <= char_count;
    end else if (cmd.out_load) begin
      rd_ptr <= rd_ptr - itar_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ascii_char   <= rd_data;
      last_char    <= rd_ptr == '0;
      empty_string <= 1'b0;
    end else if (cmd.out_empty) begin
      ascii_char   <= itar_pkg::CHAR_NONE;
      last_char    <= 1'b1;
      empty_string <= 1'b1;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_string |-> last_char && ascii_char == itar_pkg::CHAR_NONE)
    else $error("empty result must be a single last character");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= itar_pkg::ADDR_W'(itar_pkg::STORE_DEPTH))
    else $error("character count beyond store depth");

  a_no_write_during_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !wr_en && !cmd.load)
    else $error("store or load disturbs a running division");

endmodule

### sv/int_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// int_to_ascii_radix_top
// Converts a signed 32-bit integer to lower-case ASCII text in radix 2..36.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, number) takes one integer per transfer.
//   Output channel (out_valid/out_stall) delivers one character per transfer,
//   most significant first, with a leading '-' for negative numbers and
//   last_char set on the final one. An invalid radix gives one transfer with
//   empty_string and last_char set and ascii_char zero.
//   The radix register is written through cfg_wr_en/cfg_wr_data; the user
//   must do so only while idle, which the block itself does not enforce.
// Operation:
//   Each digit takes 32 steps of the bit-serial divider and is then stored.
//   A sign, if any, is stored after the digits, and each character then
//   passes through the store read port and the output register.
//   A new number is taken once the last character sits in the output register.
// Reset: rst (synchronous) sets the radix to 10 and empties the output.
// A stalled receiver holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module int_to_ascii_radix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [itar_pkg::RADIX_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [itar_pkg::VALUE_W-1:0] number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [itar_pkg::CHAR_W-1:0]         ascii_char,
  output logic                                last_char,
  output logic                                empty_string
);

  itar_pkg::ctrl_cmd_t cmd;
  itar_pkg::ctrl_sts_t sts;

  itar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itar_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .number       (number),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ascii_char   (ascii_char),
    .last_char    (last_char),
    .empty_string (empty_string)
  );

endmodule
